// ===== rtl/tcbb_pkg.sv =====
package tcbb_pkg;

    // Default screen geometry
    localparam int COLS_DEF = 80;
    localparam int ROWS_DEF = 25;

    // Field widths of one command beat
    localparam int CMD_W   = 2;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CODE_W  = 21;
    localparam int COLOR_W = 4;
    localparam int CELL_W  = 16;

    // Character substituted for codes outside one byte
    localparam logic [7:0]        CHAR_QMARK = 8'h3F;
    localparam logic [CODE_W-1:0] CHAR_MAX   = CODE_W'(255);

    typedef enum logic [CMD_W-1:0] {
        CMD_SET  = 2'd0,
        CMD_COPY = 2'd1,
        CMD_READ = 2'd2
    } cmd_t;

    // Control handed from the sequencer to the copy walker
    typedef struct packed {
        logic start;
        logic col_inc;   // walk columns left to right
        logic row_inc;   // walk rows top to bottom
    } walk_ctl_t;

    // Cell layout: bg in the top nibble, fg below it, character byte at the bottom
    function automatic logic [CELL_W-1:0] pack_cell(input logic [COLOR_W-1:0] bg,
                                                    input logic [COLOR_W-1:0] fg,
                                                    input logic [CODE_W-1:0]  code);
        logic [7:0] ch;
        ch = (code > CHAR_MAX) ? CHAR_QMARK : code[7:0];
        return {bg, fg, ch};
    endfunction

endpackage

// ===== rtl/tcbb_ram.sv =====
module tcbb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tcbb_walk.sv =====
module tcbb_walk #(
    parameter int COLS = tcbb_pkg::COLS_DEF,
    parameter int ROWS = tcbb_pkg::ROWS_DEF,
    parameter int AW   = (COLS * ROWS > 1) ? $clog2(COLS * ROWS) : 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  tcbb_pkg::walk_ctl_t      ctl,
    input  logic [AW-1:0]            src_start,
    input  logic [AW-1:0]            dst_start,
    input  logic [tcbb_pkg::COL_W-1:0] rect_w,
    input  logic [tcbb_pkg::ROW_W-1:0] rect_h,
    output logic                     rd_en,
    output logic [AW-1:0]            rd_addr,
    output logic                     wr_en,
    output logic [AW-1:0]            wr_addr,
    output logic                     done
);

    import tcbb_pkg::*;

    localparam logic [AW-1:0] ROW_STEP = AW'(COLS);
    localparam logic [AW-1:0] ONE      = AW'(1);

    logic             active_reg,   active_next;
    logic             wr_valid_reg, wr_valid_next;
    logic [AW-1:0]    wr_addr_reg,  wr_addr_next;
    logic [COL_W-1:0] col_cnt_reg,  col_cnt_next;
    logic [ROW_W-1:0] row_cnt_reg,  row_cnt_next;
    logic [COL_W-1:0] w_last_reg,   w_last_next;
    logic [ROW_W-1:0] h_last_reg,   h_last_next;
    logic [AW-1:0]    src_addr_reg, src_addr_next;
    logic [AW-1:0]    dst_addr_reg, dst_addr_next;
    logic [AW-1:0]    src_line_reg, src_line_next;
    logic [AW-1:0]    dst_line_reg, dst_line_next;
    logic             col_inc_reg,  col_inc_next;
    logic             row_inc_reg,  row_inc_next;

    logic          col_end;
    logic [AW-1:0] src_line_step;
    logic [AW-1:0] dst_line_step;

    assign col_end       = (col_cnt_reg == w_last_reg);
    assign src_line_step = row_inc_reg ? (src_line_reg + ROW_STEP) : (src_line_reg - ROW_STEP);
    assign dst_line_step = row_inc_reg ? (dst_line_reg + ROW_STEP) : (dst_line_reg - ROW_STEP);

    // address walk: one source read per cycle, its write follows in the next cycle
    always_comb begin
        active_next   = active_reg;
        wr_valid_next = active_reg;
        wr_addr_next  = dst_addr_reg;
        col_cnt_next  = col_cnt_reg;
        row_cnt_next  = row_cnt_reg;
        w_last_next   = w_last_reg;
        h_last_next   = h_last_reg;
        src_addr_next = src_addr_reg;
        dst_addr_next = dst_addr_reg;
        src_line_next = src_line_reg;
        dst_line_next = dst_line_reg;
        col_inc_next  = col_inc_reg;
        row_inc_next  = row_inc_reg;

        if (ctl.start) begin
            active_next   = 1'b1;
            col_cnt_next  = '0;
            row_cnt_next  = '0;
            w_last_next   = rect_w - COL_W'(1);
            h_last_next   = rect_h - ROW_W'(1);
            src_addr_next = src_start;
            dst_addr_next = dst_start;
            src_line_next = src_start;
            dst_line_next = dst_start;
            col_inc_next  = ctl.col_inc;
            row_inc_next  = ctl.row_inc;
        end else if (active_reg) begin
            if (col_end) begin
                col_cnt_next  = '0;
                row_cnt_next  = row_cnt_reg + ROW_W'(1);
                src_line_next = src_line_step;
                dst_line_next = dst_line_step;
                src_addr_next = src_line_step;
                dst_addr_next = dst_line_step;
                if (row_cnt_reg == h_last_reg) begin
                    active_next = 1'b0;
                end
            end else begin
                col_cnt_next  = col_cnt_reg + COL_W'(1);
                src_addr_next = col_inc_reg ? (src_addr_reg + ONE) : (src_addr_reg - ONE);
                dst_addr_next = col_inc_reg ? (dst_addr_reg + ONE) : (dst_addr_reg - ONE);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            wr_valid_reg <= 1'b0;
        end else begin
            active_reg   <= active_next;
            wr_valid_reg <= wr_valid_next;
        end
        wr_addr_reg  <= wr_addr_next;
        col_cnt_reg  <= col_cnt_next;
        row_cnt_reg  <= row_cnt_next;
        w_last_reg   <= w_last_next;
        h_last_reg   <= h_last_next;
        src_addr_reg <= src_addr_next;
        dst_addr_reg <= dst_addr_next;
        src_line_reg <= src_line_next;
        dst_line_reg <= dst_line_next;
        col_inc_reg  <= col_inc_next;
        row_inc_reg  <= row_inc_next;
    end

    assign rd_en   = active_reg;
    assign rd_addr = src_addr_reg;
    assign wr_en   = wr_valid_reg;
    assign wr_addr = wr_addr_reg;
    assign done    = wr_valid_reg && !active_reg;

endmodule

// ===== rtl/text_cell_buffer_blitter_unit.sv =====
// Channel  | dir | payload                                   | handshake
// s_       | in  | tuser: cmd; tdata: col..dest_row (72 b)   | s_tvalid / s_tready
// m_       | out | tdata: cell_value, rejected (24 b)        | m_tvalid / m_tready
//
// Set, read and rejected commands pass ST_CALC, ST_EXEC (an accepted read then ST_RDWAIT) and ST_DONE.
// In a copy the walker moves one cell per cycle through the single write port
// of the cell memory.
// After reset a clearing pass zeroes all COLS*ROWS cells; s_tready stays low
// during it.
// A finished result waits in the output register; the next beat is taken
// meanwhile, and the following result holds until the register drains.
module text_cell_buffer_blitter_unit #(
    parameter int COLS = tcbb_pkg::COLS_DEF,
    parameter int ROWS = tcbb_pkg::ROWS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // col[6:0] row[11:7] char_code[32:12] fg_color[36:33] bg_color[40:37]
    // rect_width[47:41] rect_height[52:48] dest_col[59:53] dest_row[64:60]
    input  logic [71:0] s_tdata,
    // cmd[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // cell_value[15:0] rejected[16]
    output logic [23:0] m_tdata
);

    import tcbb_pkg::*;

    localparam int CELLS = COLS * ROWS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int BW    = 10;   // bounds arithmetic, holds 255 + 127
    localparam logic [BW-1:0] COLS_B = BW'(COLS);
    localparam logic [BW-1:0] ROWS_B = BW'(ROWS);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_CALC   = 7'b0000100,
        ST_EXEC   = 7'b0001000,
        ST_RDWAIT = 7'b0010000,
        ST_COPY   = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0] clr_reg, clr_next;

    // captured command
    cmd_t               cmd_reg;
    logic [COL_W-1:0]   col_reg, w_reg, dc_reg;
    logic [ROW_W-1:0]   row_reg, h_reg, dr_reg;
    logic [CODE_W-1:0]  code_reg;
    logic [COLOR_W-1:0] fg_reg, bg_reg;

    // decoded command
    logic [AW-1:0]     src_start_reg, src_start_next;
    logic [AW-1:0]     dst_start_reg, dst_start_next;
    logic              rej_reg, rej_next;
    logic              col_inc_reg, col_inc_next;
    logic              row_inc_reg, row_inc_next;
    logic [CELL_W-1:0] value_reg, value_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [CELL_W-1:0] m_value_reg, m_value_next;
    logic              m_rej_reg, m_rej_next;

    // memory and walker
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [CELL_W-1:0] ram_wdata, ram_rdata;
    walk_ctl_t         walk_ctl;
    logic              walk_rd_en, walk_wr_en, walk_done;
    logic [AW-1:0]     walk_rd_addr, walk_wr_addr;

    logic              accept, out_free, empty_rect;
    logic              on_screen, rect_ok;
    logic [7:0]        src_c, dst_c;
    logic [5:0]        src_r, dst_r;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign empty_rect = (w_reg == '0) || (h_reg == '0);

    // bounds checks and start corners
    always_comb begin
        on_screen = (BW'(col_reg) < COLS_B) && (BW'(row_reg) < ROWS_B);
        rect_ok   = (BW'(col_reg) + BW'(w_reg) <= COLS_B) &&
                    (BW'(row_reg) + BW'(h_reg) <= ROWS_B) &&
                    (BW'(dc_reg) + BW'(w_reg) <= COLS_B) &&
                    (BW'(dr_reg) + BW'(h_reg) <= ROWS_B);
        // walk away from the overlap, as memmove would
        col_inc_next = (cmd_reg != CMD_COPY) || !(dc_reg > col_reg);
        row_inc_next = (cmd_reg != CMD_COPY) || (dr_reg < row_reg);
        src_c = col_inc_next ? {1'b0, col_reg} : ({1'b0, col_reg} + {1'b0, w_reg} - 8'd1);
        dst_c = col_inc_next ? {1'b0, dc_reg}  : ({1'b0, dc_reg} + {1'b0, w_reg} - 8'd1);
        src_r = row_inc_next ? {1'b0, row_reg} : ({1'b0, row_reg} + {1'b0, h_reg} - 6'd1);
        dst_r = row_inc_next ? {1'b0, dr_reg}  : ({1'b0, dr_reg} + {1'b0, h_reg} - 6'd1);
        src_start_next = AW'(int'(src_r) * COLS + int'(src_c));
        dst_start_next = AW'(int'(dst_r) * COLS + int'(dst_c));
        case (cmd_reg)
            CMD_SET:  rej_next = !on_screen;
            CMD_READ: rej_next = !on_screen;
            CMD_COPY: rej_next = !rect_ok;
            default:  rej_next = 1'b0;
        endcase
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        value_next   = value_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_value_next = m_value_reg;
        m_rej_next   = m_rej_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(CELLS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                value_next = '0;
                case (cmd_reg)
                    CMD_READ: state_next = rej_reg ? ST_DONE : ST_RDWAIT;
                    CMD_COPY: state_next = (rej_reg || empty_rect) ? ST_DONE : ST_COPY;
                    default:  state_next = ST_DONE;
                endcase
            end
            ST_RDWAIT: begin
                value_next = ram_rdata;
                state_next = ST_DONE;
            end
            ST_COPY: begin
                if (walk_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_value_next = value_reg;
                    m_rej_next   = rej_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // memory port steering
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = walk_wr_addr;
        ram_wdata = ram_rdata;
        ram_re    = walk_rd_en;
        ram_raddr = walk_rd_addr;
        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            ST_EXEC: begin
                ram_waddr = src_start_reg;
                ram_wdata = pack_cell(bg_reg, fg_reg, code_reg);
                ram_raddr = src_start_reg;
                ram_we    = (cmd_reg == CMD_SET) && !rej_reg;
                ram_re    = (cmd_reg == CMD_READ) && !rej_reg;
            end
            ST_COPY: begin
                ram_we = walk_wr_en;
            end
            default: ram_we = 1'b0;
        endcase
    end

    assign walk_ctl.start   = (state_reg == ST_EXEC) && (cmd_reg == CMD_COPY) &&
                              !rej_reg && !empty_rect;
    assign walk_ctl.col_inc = col_inc_reg;
    assign walk_ctl.row_inc = row_inc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
        if (accept) begin
            cmd_reg  <= cmd_t'(s_tuser);
            col_reg  <= s_tdata[6:0];
            row_reg  <= s_tdata[11:7];
            code_reg <= s_tdata[32:12];
            fg_reg   <= s_tdata[36:33];
            bg_reg   <= s_tdata[40:37];
            w_reg    <= s_tdata[47:41];
            h_reg    <= s_tdata[52:48];
            dc_reg   <= s_tdata[59:53];
            dr_reg   <= s_tdata[64:60];
        end
        if (state_reg == ST_CALC) begin
            src_start_reg <= src_start_next;
            dst_start_reg <= dst_start_next;
            rej_reg       <= rej_next;
            col_inc_reg   <= col_inc_next;
            row_inc_reg   <= row_inc_next;
        end
        value_reg   <= value_next;
        m_value_reg <= m_value_next;
        m_rej_reg   <= m_rej_next;
    end

    tcbb_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_cells (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tcbb_walk #(
        .COLS (COLS),
        .ROWS (ROWS),
        .AW   (AW)
    ) u_walk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (walk_ctl),
        .src_start (src_start_reg),
        .dst_start (dst_start_reg),
        .rect_w    (w_reg),
        .rect_h    (h_reg),
        .rd_en     (walk_rd_en),
        .rd_addr   (walk_rd_addr),
        .wr_en     (walk_wr_en),
        .wr_addr   (walk_wr_addr),
        .done      (walk_done)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_rej_reg, m_value_reg};

`ifndef SYNTH
    // nothing may write the cell store while waiting for a command
    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !ram_we)
        else $error("cell store written while idle");

    // the walker only finishes inside a copy
    a_walk_in_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_done |-> (state_reg == ST_COPY))
        else $error("copy walker active outside a copy");

    // copy reads stay inside the screen
    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (walk_rd_en && (state_reg == ST_COPY)) |-> (int'(walk_rd_addr) < CELLS))
        else $error("copy read beyond the screen");

    // a rejected beat never carries cell data
    a_rej_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_rej_reg) |-> (m_value_reg == '0))
        else $error("rejected result with non-zero cell value");
`endif

endmodule

// ===== bench/text_cell_buffer_blitter_unit_tb.sv =====
module text_cell_buffer_blitter_unit_tb;
    import tcbb_pkg::*;

    localparam int NCOLS  = COLS_DEF;
    localparam int NROWS  = ROWS_DEF;
    localparam int NCELLS = NCOLS * NROWS;

    // cmd 3 has no meaning; the block answers it with an empty result
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int BEATS_PER_PHASE = 31;
    localparam int TAIL_CYCLES = 50;
    localparam int MAX_REPORTS = 10;

    // One command beat, plus an optional hand-written expectation
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [CODE_W-1:0]  code;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        logic [COL_W-1:0]   w;
        logic [ROW_W-1:0]   h;
        logic [COL_W-1:0]   dc;
        logic [ROW_W-1:0]   dr;
        logic               typed;
        logic [CELL_W-1:0]  value;
        logic               rej;
    } cell_cmd_t;

    typedef struct packed {
        logic [CELL_W-1:0] value;
        logic              rej;
    } cell_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    // Hand-written expectation travelling alongside the beat on the bus
    logic         beat_typed = 1'b0;
    cell_result_t beat_typed_res = '0;

    logic [CELL_W-1:0] screen_shadow [NCELLS];
    logic [CELL_W-1:0] screen_snap [NCELLS];
    cell_result_t      pending_results [$];
    cell_cmd_t         directed_rows [$];

    int idle_pct = 0;
    int stall_pct = 0;
    int fail_count = 0;
    int idle_cycles = 0;
    int n_set = 0, n_copy = 0, n_read = 0, n_unused = 0, n_rej = 0;

    text_cell_buffer_blitter_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Shadow screen: applies one command and returns the result it should give
    task automatic apply_cell_cmd(input logic [1:0] cmd, input logic [71:0] d,
                                  output cell_result_t res);
        logic [COL_W-1:0]   col, w, dc;
        logic [ROW_W-1:0]   row, h, dr;
        logic [CODE_W-1:0]  code;
        logic [COLOR_W-1:0] fg, bg;
        logic [7:0]         ch;
        bit                 on_screen;
        int                 i, j;
        col  = d[6:0];
        row  = d[11:7];
        code = d[32:12];
        fg   = d[36:33];
        bg   = d[40:37];
        w    = d[47:41];
        h    = d[52:48];
        dc   = d[59:53];
        dr   = d[64:60];
        res = '0;
        on_screen = (int'(col) < NCOLS) && (int'(row) < NROWS);
        case (cmd)
            CMD_SET: begin
                if (on_screen) begin
                    ch = (code > CHAR_MAX) ? CHAR_QMARK : code[7:0];
                    screen_shadow[int'(row) * NCOLS + int'(col)] = {bg, fg, ch};
                end else begin
                    res.rej = 1'b1;
                end
            end
            CMD_COPY: begin
                if (int'(col) + int'(w) <= NCOLS && int'(row) + int'(h) <= NROWS &&
                    int'(dc) + int'(w) <= NCOLS && int'(dr) + int'(h) <= NROWS) begin
                    // snapshot first, so overlap never matters
                    for (i = 0; i < NCELLS; i++)
                        screen_snap[i] = screen_shadow[i];
                    for (i = 0; i < int'(h); i++)
                        for (j = 0; j < int'(w); j++)
                            screen_shadow[(int'(dr) + i) * NCOLS + int'(dc) + j] =
                                screen_snap[(int'(row) + i) * NCOLS + int'(col) + j];
                end else begin
                    res.rej = 1'b1;
                end
            end
            CMD_READ: begin
                if (on_screen)
                    res.value = screen_shadow[int'(row) * NCOLS + int'(col)];
                else
                    res.rej = 1'b1;
            end
            default: ;
        endcase
    endtask

    function automatic cell_cmd_t cell_row(logic [1:0] cmd, int col, int row, int code,
                                           int fg, int bg, bit typed, int value, bit rej);
        cell_cmd_t r;
        r = '0;
        r.cmd = cmd;
        r.col = COL_W'(col);
        r.row = ROW_W'(row);
        r.code = CODE_W'(code);
        r.fg = COLOR_W'(fg);
        r.bg = COLOR_W'(bg);
        r.typed = typed;
        r.value = CELL_W'(value);
        r.rej = rej;
        return r;
    endfunction

    function automatic cell_cmd_t copy_row(int col, int row, int w, int h, int dc, int dr,
                                           bit typed, bit rej);
        cell_cmd_t r;
        r = '0;
        r.cmd = CMD_COPY;
        r.col = COL_W'(col);
        r.row = ROW_W'(row);
        r.w = COL_W'(w);
        r.h = ROW_W'(h);
        r.dc = COL_W'(dc);
        r.dr = ROW_W'(dr);
        r.typed = typed;
        r.rej = rej;
        return r;
    endfunction

    // Random beat: mostly in-bounds work in a small corner so reads see earlier writes
    function automatic cell_cmd_t random_cmd();
        cell_cmd_t r;
        int  pick, lim_c, lim_r;
        bit  narrow;
        r = '0;
        pick = $urandom_range(0, 99);
        narrow = ($urandom_range(0, 9) < 7);
        lim_c = narrow ? 16 : NCOLS;
        lim_r = narrow ? 6 : NROWS;
        case ($urandom_range(0, 3))
            0:       r.code = CODE_W'($urandom);
            1:       r.code = CODE_W'($urandom_range(0, 1114111));
            default: r.code = CODE_W'($urandom_range(0, 255));
        endcase
        r.fg = COLOR_W'($urandom);
        r.bg = COLOR_W'($urandom);
        r.w  = COL_W'($urandom);
        r.h  = ROW_W'($urandom);
        r.dc = COL_W'($urandom);
        r.dr = ROW_W'($urandom);
        r.col = COL_W'($urandom_range(0, lim_c - 1));
        r.row = ROW_W'($urandom_range(0, lim_r - 1));
        if (pick < 35) begin
            r.cmd = CMD_SET;
        end else if (pick < 65) begin
            r.cmd = CMD_READ;
        end else if (pick < 88) begin
            r.cmd = CMD_COPY;
            if ($urandom_range(0, 19) == 0) begin
                // the odd big block
                r.w = COL_W'($urandom_range(40, NCOLS));
                r.h = ROW_W'($urandom_range(10, NROWS));
                lim_c = NCOLS;
                lim_r = NROWS;
            end else begin
                r.w = COL_W'($urandom_range(0, 6));
                r.h = ROW_W'($urandom_range(0, 4));
            end
            r.col = COL_W'($urandom_range(0, lim_c - int'(r.w)));
            r.row = ROW_W'($urandom_range(0, lim_r - int'(r.h)));
            r.dc  = COL_W'($urandom_range(0, lim_c - int'(r.w)));
            r.dr  = ROW_W'($urandom_range(0, lim_r - int'(r.h)));
        end else begin
            // noise: any command, any field value
            r.cmd = CMD_W'($urandom);
            r.col = COL_W'($urandom);
            r.row = ROW_W'($urandom);
        end
        return r;
    endfunction

    // Present one beat, with a random gap first; valid stays high on return
    task automatic drive_beat(input cell_cmd_t c);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.cmd;
        s_tdata  <= {7'd0, c.dr, c.dc, c.h, c.w, c.bg, c.fg, c.code, c.row, c.col};
        beat_typed     <= c.typed;
        beat_typed_res <= {c.value, c.rej};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold off the sender until every result has come back
    task automatic drain_pause();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Accepted command beats: predict and queue the result
    always @(posedge aclk) begin
        cell_result_t pred;
        if (aresetn && s_tvalid && s_tready) begin
            apply_cell_cmd(s_tuser, s_tdata, pred);
            pending_results.push_back(beat_typed ? beat_typed_res : pred);
            case (s_tuser)
                CMD_SET:  n_set++;
                CMD_COPY: n_copy++;
                CMD_READ: n_read++;
                default:  n_unused++;
            endcase
            if (pred.rej)
                n_rej++;
        end
    end

    // Result beats: compare against the oldest expectation
    always @(posedge aclk) begin
        cell_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result beat: cell_value %h rejected %b",
                             m_tdata[15:0], m_tdata[16]);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[15:0] !== want.value || m_tdata[16] !== want.rej) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("mismatch: cell_value exp %h got %h, rejected exp %b got %b",
                                 want.value, m_tdata[15:0], want.rej, m_tdata[16]);
                end
            end
        end
    end

    // Watchdog on cycles with no beat moving on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int        i, ph, n;
        cell_cmd_t c;
        for (i = 0; i < NCELLS; i++)
            screen_shadow[i] = '0;

        // Directed rows; expected results typed in where obvious
        directed_rows.push_back(cell_row(CMD_READ, 0, 0, 0, 0, 0, 1, 16'h0000, 0));
        directed_rows.push_back(cell_row(CMD_READ, 79, 24, 0, 0, 0, 1, 16'h0000, 0));
        directed_rows.push_back(cell_row(CMD_SET, 0, 0, 'h41, 15, 0, 1, 0, 0));
        directed_rows.push_back(cell_row(CMD_READ, 0, 0, 0, 0, 0, 1, 16'h0F41, 0));
        directed_rows.push_back(cell_row(CMD_SET, 79, 24, 256, 0, 15, 1, 0, 0));
        directed_rows.push_back(cell_row(CMD_READ, 79, 24, 0, 0, 0, 1, 16'hF03F, 0));
        directed_rows.push_back(cell_row(CMD_SET, 1, 0, 255, 10, 5, 1, 0, 0));
        directed_rows.push_back(cell_row(CMD_READ, 1, 0, 0, 0, 0, 1, 16'h5AFF, 0));
        directed_rows.push_back(cell_row(CMD_SET, 2, 0, 1114111, 15, 15, 1, 0, 0));
        directed_rows.push_back(cell_row(CMD_READ, 2, 0, 0, 0, 0, 1, 16'hFF3F, 0));
        // cells off the screen
        directed_rows.push_back(cell_row(CMD_SET, 80, 0, 'h41, 1, 1, 1, 0, 1));
        directed_rows.push_back(cell_row(CMD_SET, 0, 25, 'h41, 1, 1, 1, 0, 1));
        directed_rows.push_back(cell_row(CMD_READ, 127, 31, 0, 0, 0, 1, 0, 1));
        // rectangles off the screen, and empty ones
        directed_rows.push_back(copy_row(79, 0, 2, 1, 0, 0, 1, 1));
        directed_rows.push_back(copy_row(0, 0, 1, 2, 0, 24, 1, 1));
        directed_rows.push_back(copy_row(0, 0, 0, 25, 79, 0, 1, 0));
        directed_rows.push_back(copy_row(0, 0, 80, 0, 0, 24, 1, 0));
        // unused command with every field at its top
        c = cell_row(CMD_UNUSED, 127, 31, 'h1FFFFF, 15, 15, 1, 0, 0);
        c.w = '1;
        c.h = '1;
        c.dc = '1;
        c.dr = '1;
        directed_rows.push_back(c);
        // overlapping copies to the right, to the left and downward
        directed_rows.push_back(copy_row(0, 0, 3, 1, 1, 0, 0, 0));
        directed_rows.push_back(cell_row(CMD_READ, 1, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(cell_row(CMD_READ, 3, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(copy_row(1, 0, 3, 1, 0, 0, 0, 0));
        directed_rows.push_back(copy_row(0, 0, 4, 2, 0, 1, 0, 0));
        directed_rows.push_back(cell_row(CMD_READ, 1, 2, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(copy_row(0, 0, 80, 25, 0, 0, 0, 0));
        directed_rows.push_back(copy_row(79, 24, 1, 1, 0, 0, 0, 0));
        directed_rows.push_back(cell_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[k])
            drive_beat(directed_rows[k]);

        // Random beats over the idling phases, one drain pause in each
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 81; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 81; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            for (n = 0; n < BEATS_PER_PHASE; n++) begin
                if (n == BEATS_PER_PHASE / 2)
                    drain_pause();
                drive_beat(random_cmd());
            end
        end

        drain_pause();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d sets, %0d copies, %0d reads, %0d unused commands, %0d rejected",
                 n_set, n_copy, n_read, n_unused, n_rej);
        $display("idling phases: none, sender gaps, receiver stalls, both; %0d failures",
                 fail_count);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
